// ===== design/mbfu_pkg.sv =====
// ----------------------------------------------------------------------------
// mbfu_pkg
// Shared types and constants of the MSB-first bit field unpacker.
// ----------------------------------------------------------------------------
package mbfu_pkg;

    // Stream offset counter width
    localparam int OFFSET_WIDTH = 20;

    // Field width register and field word
    localparam int FW_W    = 7;
    localparam int FIELD_W = 64;
    localparam int BYTE_W  = 8;

    // Bit buffer: one full field plus one byte of slack
    localparam int BUF_W = FIELD_W + BYTE_W;

    // Count of bits a byte yields after skipping (0..8)
    localparam int NBITS_W = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = (OFFSET_WIDTH > FW_W) ? OFFSET_WIDTH : FW_W;

    localparam logic [FW_W-1:0] MAX_FIELD = FW_W'(FIELD_W);
    localparam logic [FW_W-1:0] MIN_FIELD = FW_W'(1);

    // Byte queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIELD_WIDTH  = 1'b0,
        CFG_START_OFFSET = 1'b1
    } t_cfg_index;

    // One classified byte: stream bits left-aligned, how many, end of buffer
    typedef struct packed {
        logic [BYTE_W-1:0]  bits;
        logic [NBITS_W-1:0] cnt;
        logic               last;
    } t_q_entry;

endpackage

// ===== design/mbfu_front.sv =====
// ----------------------------------------------------------------------------
// mbfu_front
// Accepts bytes, drops the leading offset bits and pushes each byte's
// remaining bits, left-aligned with their count, into the byte queue.
// ----------------------------------------------------------------------------
module mbfu_front
    import mbfu_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [BYTE_W-1:0]       i_data_byte,
    input  logic                    i_last_byte,
    input  logic                    i_q_full,
    input  logic                    i_reload,
    input  logic [OFFSET_WIDTH-1:0] i_reload_value,
    input  logic [OFFSET_WIDTH-1:0] i_start_offset,
    output logic                    o_push,
    output t_q_entry                o_entry
);

    localparam logic [OFFSET_WIDTH-1:0] SKIP_BYTE = OFFSET_WIDTH'(BYTE_W);

    logic [OFFSET_WIDTH-1:0] r_skip;
    logic [OFFSET_WIDTH-1:0] n_skip;
    logic                    accept;
    logic                    whole_skip;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign whole_skip = (r_skip >= SKIP_BYTE);
    assign o_push     = accept;

    always_comb begin
        o_entry.last = i_last_byte;
        if (whole_skip) begin
            o_entry.bits = '0;
            o_entry.cnt  = '0;
            n_skip       = r_skip - SKIP_BYTE;
        end else begin
            // skip is below 8 here: drop that many bits off the top
            o_entry.bits = i_data_byte << r_skip[2:0];
            o_entry.cnt  = NBITS_W'(BYTE_W) - NBITS_W'(r_skip[2:0]);
            n_skip       = '0;
        end
        // end of buffer starts a new stream
        if (i_last_byte) begin
            n_skip = i_start_offset;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip <= '0;
        end else if (i_reload) begin
            r_skip <= i_reload_value;
        end else if (accept) begin
            r_skip <= n_skip;
        end
    end

endmodule

// ===== design/mbfu_queue.sv =====
// ----------------------------------------------------------------------------
// mbfu_queue
// Short FIFO of classified bytes between front and back.
// ----------------------------------------------------------------------------
module mbfu_queue
    import mbfu_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_q_entry i_entry,
    output logic     o_full,
    input  logic     i_pop,
    output logic     o_valid,
    output t_q_entry o_entry
);

    t_q_entry             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wp;
    logic [Q_PTR_W-1:0]   r_rp;
    logic [Q_CNT_W-1:0]   r_cnt;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + Q_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + Q_CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - Q_CNT_W'(1);
            end
        end
    end

endmodule

// ===== design/mbfu_back.sv =====
// ----------------------------------------------------------------------------
// mbfu_back
// Bit buffer: appends queued bits, cuts fields off the top, gives the tail
// at end of buffer, and drives the output register.
// ----------------------------------------------------------------------------
module mbfu_back
    import mbfu_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [FW_W-1:0]    i_width,
    input  logic               i_restart,
    input  logic               i_q_valid,
    input  t_q_entry           i_q_entry,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [FIELD_W-1:0] o_field_value,
    output logic [FW_W-1:0]    o_field_bits,
    output logic               o_last_field
);

    logic [BUF_W-1:0]   r_buf;
    logic [BUF_W-1:0]   n_buf;
    logic [FW_W-1:0]    r_held;
    logic [FW_W-1:0]    n_held;
    logic               r_drain;
    logic               n_drain;
    logic               r_out_valid;
    logic [FIELD_W-1:0] r_value;
    logic [FW_W-1:0]    r_bits;
    logic               r_last;

    logic               emit_ok;
    logic               fire_full;
    logic               fire_tail;
    logic               exact_end;
    logic [FIELD_W-1:0] full_mask;
    logic [BUF_W-1:0]   buf1;
    logic [FW_W-1:0]    held1;
    logic [BUF_W-1:0]   ins;
    logic               pop;

    always_comb begin
        emit_ok   = !r_out_valid || !i_out_stall;
        fire_full = (r_held >= i_width) && emit_ok;
        fire_tail = r_drain && (r_held < i_width) && emit_ok;
        exact_end = r_drain && (r_held == i_width);
        full_mask = ~({FIELD_W{1'b1}} >> i_width);

        buf1  = fire_full ? (r_buf << i_width) : r_buf;
        held1 = fire_full ? (r_held - i_width) : r_held;

        // room for a whole byte after this cycle's cut
        pop = i_q_valid && !r_drain && (held1 <= MAX_FIELD);
        ins = {i_q_entry.bits, {FIELD_W{1'b0}}} >> held1;

        n_buf   = buf1;
        n_held  = held1;
        n_drain = r_drain;

        if (fire_tail || (fire_full && exact_end)) begin
            n_buf   = '0;
            n_held  = '0;
            n_drain = 1'b0;
        end
        if (pop) begin
            n_buf  = buf1 | ins;
            n_held = held1 + FW_W'(i_q_entry.cnt);
            // end of buffer with bits still pending, new or older
            if (i_q_entry.last && (n_held != '0)) begin
                n_drain = 1'b1;
            end
        end
        if (i_restart) begin
            n_buf   = '0;
            n_held  = '0;
            n_drain = 1'b0;
        end
    end

    assign o_q_pop = pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf       <= '0;
            r_held      <= '0;
            r_drain     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_buf   <= n_buf;
            r_held  <= n_held;
            r_drain <= n_drain;
            if (emit_ok) begin
                r_out_valid <= fire_full || fire_tail;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire_full) begin
            r_value <= r_buf[BUF_W-1:BYTE_W] & full_mask;
            r_bits  <= i_width;
            r_last  <= exact_end;
        end else if (fire_tail) begin
            r_value <= r_buf[BUF_W-1:BYTE_W];
            r_bits  <= r_held;
            r_last  <= 1'b1;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_field_value = r_value;
    assign o_field_bits  = r_bits;
    assign o_last_field  = r_last;

endmodule

// ===== design/msb_bit_field_unpacker.sv =====
// A byte's first field goes through the byte queue, bit buffer and output register.
// Throughput, output not stalled: one byte per cycle while each byte yields at most
//   one field; otherwise one field per cycle, set by the single output register.
// The end of a buffer holds the byte queue until its remaining fields have left.
// Reset (synchronous, active low): width 8, offset 0, queue and bit buffer empty.
// ----------------------------------------------------------------------------
// msb_bit_field_unpacker
// Reads a byte stream MSB first, skips a leading bit offset and cuts the rest
// into fields of 1 to 64 bits, left-aligned in a 64-bit word.
// ----------------------------------------------------------------------------
module msb_bit_field_unpacker
    import mbfu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // byte input
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [BYTE_W-1:0]     i_data_byte,
    input  logic                  i_last_byte,
    // field output
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [FIELD_W-1:0]    o_field_value,
    output logic [FW_W-1:0]       o_field_bits,
    output logic                  o_last_field,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Config registers. The raw width is kept; 0 reads as 1, above 64 as 64.
    logic [FW_W-1:0]         r_field_width;
    logic [OFFSET_WIDTH-1:0] r_start_offset;
    logic [FW_W-1:0]         eff_width;

    logic                    wr_width;
    logic                    wr_offset;
    logic                    reload;
    logic [OFFSET_WIDTH-1:0] reload_value;

    logic     q_full;
    logic     q_push;
    t_q_entry q_in;
    logic     q_valid;
    logic     q_pop;
    t_q_entry q_out;

    assign wr_width  = i_cfg_we && (i_cfg_index == CFG_FIELD_WIDTH);
    assign wr_offset = i_cfg_we && (i_cfg_index == CFG_START_OFFSET);

    // A width write starts a fresh stream; an offset write reloads the skip
    // count with the new value right away.
    assign reload       = wr_width || wr_offset;
    assign reload_value = wr_offset ? i_cfg_data[OFFSET_WIDTH-1:0] : r_start_offset;

    always_comb begin
        if (r_field_width == '0) begin
            eff_width = MIN_FIELD;
        end else if (r_field_width > MAX_FIELD) begin
            eff_width = MAX_FIELD;
        end else begin
            eff_width = r_field_width;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_width  <= FW_W'(8);
            r_start_offset <= '0;
        end else begin
            if (wr_width) begin
                r_field_width <= i_cfg_data[FW_W-1:0];
            end
            if (wr_offset) begin
                r_start_offset <= i_cfg_data[OFFSET_WIDTH-1:0];
            end
        end
    end

    // Front: offset skipping, one byte per transfer
    mbfu_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .i_q_full       (q_full),
        .i_reload       (reload),
        .i_reload_value (reload_value),
        .i_start_offset (r_start_offset),
        .o_push         (q_push),
        .o_entry        (q_in)
    );

    // Decoupling queue: the front keeps taking bytes while fields back up, until it is full
    mbfu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (q_out)
    );

    // Back: bit buffer and field cutter with output register
    mbfu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_width       (eff_width),
        .i_restart     (wr_width),
        .i_q_valid     (q_valid),
        .i_q_entry     (q_out),
        .o_q_pop       (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_field_value (o_field_value),
        .o_field_bits  (o_field_bits),
        .o_last_field  (o_last_field)
    );

endmodule

// ===== design/mbfu_checker.sv =====
// ----------------------------------------------------------------------------
// mbfu_checker
// Port-level checks of the bit field unpacker, bound to the top level.
// ----------------------------------------------------------------------------
module mbfu_checker
    import mbfu_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [FIELD_W-1:0]    o_field_value,
    input logic [FW_W-1:0]       o_field_bits,
    input logic                  o_last_field
);

    // stalled field stays offered and unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_field_value) && $stable(o_field_bits)
             && $stable(o_last_field)))
        else $error("stalled output changed");

    // bit count of an offered field is always 1..64
    a_bits_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_field_bits != '0) && (o_field_bits <= MAX_FIELD)))
        else $error("field bit count out of range");

    // bits below the field are zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((o_field_value & ({FIELD_W{1'b1}} >> o_field_bits)) == '0))
        else $error("field padding not zero");

    // nothing is offered right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind msb_bit_field_unpacker mbfu_checker u_mbfu_checker (.*);
